/* hdl/vtt_pkg.sv */
// Shared widths and types for the velocity-toward-target pipeline.
// No dependencies; imported by every module of the block.
package vtt_pkg;

  localparam int CoordW = 24;              // Q16.8 coordinate and speed
  localparam int DiffW  = CoordW + 1;      // signed difference
  localparam int ProdW  = 2 * CoordW;      // 24 x 24 product
  localparam int SumW   = ProdW + 1;       // sum of squares
  localparam int RadW   = 66;              // radicand, sum << 16, padded to bit pairs
  localparam int RootW  = RadW / 2;        // root bits, one per sqrt stage
  localparam int RemW   = RootW + 3;       // sqrt partial remainder
  localparam int NumW   = ProdW + 8;       // dividend, product << 8
  localparam int QuoW   = CoordW;          // quotient never exceeds the speed
  localparam int OutW   = CoordW + 1;      // signed Q16.8 velocity
  localparam int DremW  = RootW;           // divider partial remainder
  localparam int FrontLat = 4;
  localparam int Latency  = FrontLat + RootW + QuoW + 1;

  // Side data carried alongside the square root
  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic              zero;
    logic [CoordW-1:0] mag;
    logic [NumW-1:0]   num_x;
    logic [NumW-1:0]   num_y;
  } side_t;

  // Side data carried alongside the dividers
  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic              zero;
    logic [CoordW-1:0] mag;
  } div_side_t;

endpackage

/* hdl/vtt_front.sv */
// Front end: differences, absolute values, products and sum of squares.
// Depends on vtt_pkg.
module vtt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [vtt_pkg::CoordW-1:0]   start_x,
  input  logic [vtt_pkg::CoordW-1:0]   start_y,
  input  logic [vtt_pkg::CoordW-1:0]   target_x,
  input  logic [vtt_pkg::CoordW-1:0]   target_y,
  input  logic [vtt_pkg::CoordW-1:0]   magnitude,
  output logic                         out_valid,
  output logic [vtt_pkg::RadW-1:0]     rad,
  output vtt_pkg::side_t               side
);
  import vtt_pkg::*;

  logic              v1, v2, v3;
  logic [DiffW-1:0]  dx1, dy1;
  logic [CoordW-1:0] mag1, mag2, mag3;
  logic [CoordW-1:0] ax2, ay2;
  logic              nx2, ny2, nx3, ny3, zero3;
  logic [ProdW-1:0]  sqx3, sqy3, px3, py3;
  logic [SumW-1:0]   sum;

  // Hold valid bits through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  assign sum = {1'b0, sqx3} + {1'b0, sqy3};

  // Difference, absolute value, products, then the sum
  always_ff @(posedge clk) begin
    dx1  <= {target_x[CoordW-1], target_x} - {start_x[CoordW-1], start_x};
    dy1  <= {target_y[CoordW-1], target_y} - {start_y[CoordW-1], start_y};
    mag1 <= magnitude;

    nx2  <= dx1[DiffW-1];
    ny2  <= dy1[DiffW-1];
    ax2  <= dx1[DiffW-1] ? (~dx1[CoordW-1:0] + CoordW'(1)) : dx1[CoordW-1:0];
    ay2  <= dy1[DiffW-1] ? (~dy1[CoordW-1:0] + CoordW'(1)) : dy1[CoordW-1:0];
    mag2 <= mag1;

    sqx3  <= ax2 * ax2;
    sqy3  <= ay2 * ay2;
    px3   <= ax2 * mag2;
    py3   <= ay2 * mag2;
    nx3   <= nx2;
    ny3   <= ny2;
    zero3 <= (ax2 == '0) && (ay2 == '0);
    mag3  <= mag2;

    rad        <= {1'b0, sum, 16'b0};
    side.neg_x <= nx3;
    side.neg_y <= ny3;
    side.zero  <= zero3;
    side.mag   <= mag3;
    side.num_x <= {px3, 8'b0};
    side.num_y <= {py3, 8'b0};
  end

endmodule

/* hdl/vtt_sqrt.sv */
// Pipelined restoring square root, one root bit per stage.
// Depends on vtt_pkg.
module vtt_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [vtt_pkg::RadW-1:0]  rad,
  input  vtt_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [vtt_pkg::RootW-1:0] root,
  output vtt_pkg::side_t            out_side
);
  import vtt_pkg::*;

  logic              v_q    [RootW];
  logic [RemW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [RadW-1:0]   rad_q  [RootW];
  side_t             side_q [RootW];

  logic              v_i    [RootW];
  logic [RemW-1:0]   rem_i  [RootW];
  logic [RootW-1:0]  root_i [RootW];
  logic [RadW-1:0]   rad_i  [RootW];
  side_t             side_i [RootW];
  logic [RemW-1:0]   rem_sh [RootW];
  logic [RemW-1:0]   trial  [RootW];
  logic              ge     [RootW];

  // Stage inputs: the port for the first stage, the previous stage otherwise
  always_comb begin
    for (int i = 0; i < RootW; i++) begin
      if (i == 0) begin
        v_i[i]    = in_valid;
        rem_i[i]  = '0;
        root_i[i] = '0;
        rad_i[i]  = rad;
        side_i[i] = in_side;
      end else begin
        v_i[i]    = v_q[i-1];
        rem_i[i]  = rem_q[i-1];
        root_i[i] = root_q[i-1];
        rad_i[i]  = rad_q[i-1];
        side_i[i] = side_q[i-1];
      end
      rem_sh[i] = {rem_i[i][RemW-3:0], rad_i[i][RadW-1 -: 2]};
      trial[i]  = {1'b0, root_i[i], 2'b01};
      ge[i]     = rem_sh[i] >= trial[i];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RootW; i++) v_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < RootW; i++) v_q[i] <= v_i[i];
    end
  end

  // Take one root bit per stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < RootW; i++) begin
      rem_q[i]  <= ge[i] ? (rem_sh[i] - trial[i]) : rem_sh[i];
      root_q[i] <= {root_i[i][RootW-2:0], ge[i]};
      rad_q[i]  <= rad_i[i] << 2;
      side_q[i] <= side_i[i];
    end
  end

  assign out_valid = v_q[RootW-1];
  assign root      = root_q[RootW-1];
  assign out_side  = side_q[RootW-1];

endmodule

/* hdl/vtt_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on vtt_pkg.
module vtt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [vtt_pkg::RootW-1:0] norm,
  input  vtt_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [vtt_pkg::QuoW-1:0]  quo_x,
  output logic [vtt_pkg::QuoW-1:0]  quo_y,
  output vtt_pkg::div_side_t        out_side
);
  import vtt_pkg::*;

  localparam int HiW = NumW - QuoW;

  logic              v_q     [QuoW];
  logic [RootW-1:0]  dist_q  [QuoW];
  div_side_t         side_q  [QuoW];
  logic [DremW-1:0]  rem_q   [QuoW][2];
  logic [QuoW-1:0]   lo_q    [QuoW][2];
  logic [QuoW-1:0]   q_q     [QuoW][2];

  logic              v_i     [QuoW];
  logic [RootW-1:0]  dist_i  [QuoW];
  div_side_t         side_i  [QuoW];
  logic [DremW-1:0]  rem_i   [QuoW][2];
  logic [QuoW-1:0]   lo_i    [QuoW][2];
  logic [QuoW-1:0]   q_i     [QuoW][2];
  logic [DremW:0]    rem_sh  [QuoW][2];
  logic              ge      [QuoW][2];
  div_side_t         side_in;

  assign side_in = '{neg_x: in_side.neg_x, neg_y: in_side.neg_y,
                     zero: in_side.zero, mag: in_side.mag};

  // Stage inputs; the top of each dividend is already below the divisor
  always_comb begin
    for (int i = 0; i < QuoW; i++) begin
      if (i == 0) begin
        v_i[i]      = in_valid;
        dist_i[i]   = norm;
        side_i[i]   = side_in;
        rem_i[i][0] = DremW'(in_side.num_x[NumW-1 -: HiW]);
        rem_i[i][1] = DremW'(in_side.num_y[NumW-1 -: HiW]);
        lo_i[i][0]  = in_side.num_x[QuoW-1:0];
        lo_i[i][1]  = in_side.num_y[QuoW-1:0];
        q_i[i][0]   = '0;
        q_i[i][1]   = '0;
      end else begin
        v_i[i]    = v_q[i-1];
        dist_i[i] = dist_q[i-1];
        side_i[i] = side_q[i-1];
        for (int l = 0; l < 2; l++) begin
          rem_i[i][l] = rem_q[i-1][l];
          lo_i[i][l]  = lo_q[i-1][l];
          q_i[i][l]   = q_q[i-1][l];
        end
      end
      for (int l = 0; l < 2; l++) begin
        rem_sh[i][l] = {rem_i[i][l], lo_i[i][l][QuoW-1]};
        ge[i][l]     = rem_sh[i][l] >= {1'b0, dist_i[i]};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QuoW; i++) v_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < QuoW; i++) v_q[i] <= v_i[i];
    end
  end

  // Take one quotient bit per stage in each lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < QuoW; i++) begin
      dist_q[i] <= dist_i[i];
      side_q[i] <= side_i[i];
      for (int l = 0; l < 2; l++) begin
        rem_q[i][l] <= ge[i][l] ? DremW'(rem_sh[i][l] - {1'b0, dist_i[i]})
                                : DremW'(rem_sh[i][l]);
        lo_q[i][l]  <= lo_i[i][l] << 1;
        q_q[i][l]   <= {q_i[i][l][QuoW-2:0], ge[i][l]};
      end
    end
  end

  assign out_valid = v_q[QuoW-1];
  assign quo_x     = q_q[QuoW-1][0];
  assign quo_y     = q_q[QuoW-1][1];
  assign out_side  = side_q[QuoW-1];

endmodule

/* hdl/velocity_toward_target.sv */
// Velocity toward target: takes a request every clock cycle (busy stays low) and gives
// each result on velocity_x/velocity_y with done high for one cycle; the receiver cannot
// stall. A request passes the front end, the 33-stage square root, the 24-stage divider
// (one bit per stage each) and an output register. Coincident points give (speed, 0).
module velocity_toward_target (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [vtt_pkg::CoordW-1:0] start_x,
  input  logic [vtt_pkg::CoordW-1:0] start_y,
  input  logic [vtt_pkg::CoordW-1:0] target_x,
  input  logic [vtt_pkg::CoordW-1:0] target_y,
  input  logic [vtt_pkg::CoordW-1:0] magnitude,
  output logic                       done,
  output logic [vtt_pkg::OutW-1:0]   velocity_x,
  output logic [vtt_pkg::OutW-1:0]   velocity_y
);
  import vtt_pkg::*;

  logic              f_valid, s_valid, d_valid;
  logic [RadW-1:0]   rad;
  side_t             f_side, s_side;
  logic [RootW-1:0]  norm;
  logic [QuoW-1:0]   quo_x, quo_y;
  div_side_t         d_side;

  assign busy = 1'b0;

  vtt_front u_front (
    .clk, .rst,
    .in_valid (start && !busy),
    .start_x, .start_y, .target_x, .target_y, .magnitude,
    .out_valid (f_valid),
    .rad,
    .side      (f_side)
  );

  vtt_sqrt u_sqrt (
    .clk, .rst,
    .in_valid  (f_valid),
    .rad,
    .in_side   (f_side),
    .out_valid (s_valid),
    .root      (norm),
    .out_side  (s_side)
  );

  vtt_div u_div (
    .clk, .rst,
    .in_valid  (s_valid),
    .norm,
    .in_side   (s_side),
    .out_valid (d_valid),
    .quo_x,
    .quo_y,
    .out_side  (d_side)
  );

  // Apply signs, or the speed alone for coincident points
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
    if (d_side.zero) begin
      velocity_x <= {1'b0, d_side.mag};
      velocity_y <= '0;
    end else begin
      velocity_x <= d_side.neg_x ? -{1'b0, quo_x} : {1'b0, quo_x};
      velocity_y <= d_side.neg_y ? -{1'b0, quo_y} : {1'b0, quo_y};
    end
  end

endmodule

/* hdl/vtt_checker.sv */
// Port-level checks for velocity_toward_target, bound to the top level.
// Depends on vtt_pkg.
module vtt_port_checks (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [vtt_pkg::CoordW-1:0] start_x,
  input logic [vtt_pkg::CoordW-1:0] start_y,
  input logic [vtt_pkg::CoordW-1:0] target_x,
  input logic [vtt_pkg::CoordW-1:0] target_y,
  input logic [vtt_pkg::CoordW-1:0] magnitude,
  input logic                       done,
  input logic [vtt_pkg::OutW-1:0]   velocity_x,
  input logic [vtt_pkg::OutW-1:0]   velocity_y
);
  import vtt_pkg::*;

  // Every request gives a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##Latency done)
    else $error("request without result");

  // No result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("result without request");

  // Coincident points give the speed along x
  a_coincident: assert property (@(posedge clk) disable iff (rst)
    done && $past(start_x == target_x && start_y == target_y, Latency)
    |-> velocity_y == '0 && velocity_x == {1'b0, $past(magnitude, Latency)})
    else $error("coincident points result wrong");

endmodule

bind velocity_toward_target vtt_port_checks u_vtt_checker (.*);

/* tb/vtt_checker.sv */
// Checker for velocity_toward_target: watches the request and result channels,
// predicts each velocity and compares it. Depends on vtt_pkg only.
`timescale 1ns / 1ps
module vtt_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [vtt_pkg::CoordW-1:0] start_x,
  input  logic [vtt_pkg::CoordW-1:0] start_y,
  input  logic [vtt_pkg::CoordW-1:0] target_x,
  input  logic [vtt_pkg::CoordW-1:0] target_y,
  input  logic [vtt_pkg::CoordW-1:0] magnitude,
  input  logic                       done,
  input  logic [vtt_pkg::OutW-1:0]   velocity_x,
  input  logic [vtt_pkg::OutW-1:0]   velocity_y,
  output int                         fail_count,
  output int                         pending
);
  import vtt_pkg::*;

  typedef struct packed {
    logic [OutW-1:0] vx;
    logic [OutW-1:0] vy;
  } velocity_t;

  velocity_t velocity_queue[$];

  // Floor square root of a wide unsigned value, bit by bit
  function automatic logic [39:0] floor_root(input logic [79:0] s);
    logic [39:0] r;
    logic [39:0] c;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      c = r | (40'd1 << b);
      if ({40'd0, c} * {40'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // Scale one difference by speed over distance, truncating toward zero
  function automatic logic [OutW-1:0] scaled_component(input logic signed [DiffW-1:0] d,
                                                       input logic [CoordW-1:0] mag,
                                                       input logic [39:0] norm);
    logic [79:0] a;
    logic [79:0] q;
    a = (d < 0) ? 80'(-d) : 80'(d);
    q = ((a * mag) << 8) / norm;
    if (d < 0) q = -q;
    return q[OutW-1:0];
  endfunction

  function automatic velocity_t predict_velocity(input logic [CoordW-1:0] sx, sy, tx, ty,
                                                 input logic [CoordW-1:0] mag);
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic [79:0] ax;
    logic [79:0] ay;
    logic [79:0] s;
    logic [39:0] norm;
    velocity_t v;
    dx = $signed({tx[CoordW-1], tx}) - $signed({sx[CoordW-1], sx});
    dy = $signed({ty[CoordW-1], ty}) - $signed({sy[CoordW-1], sy});
    ax = (dx < 0) ? 80'(-dx) : 80'(dx);
    ay = (dy < 0) ? 80'(-dy) : 80'(dy);
    s = ax * ax + ay * ay;
    if (s == 0) begin
      v.vx = {1'b0, mag};
      v.vy = '0;
    end else begin
      norm = floor_root(s << 16);
      v.vx = scaled_component(dx, mag, norm);
      v.vy = scaled_component(dy, mag, norm);
    end
    return v;
  endfunction

  // Record each accepted request, check each result against the oldest one
  always @(posedge clk) begin
    velocity_t exp_v;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (velocity_queue.size() == 0) begin
          $display("%0t: unexpected result vx=%0h vy=%0h", $time, velocity_x, velocity_y);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = velocity_queue.pop_front();
          if (velocity_x !== exp_v.vx || velocity_y !== exp_v.vy) begin
            $display("%0t: mismatch expected vx=%0h vy=%0h actual vx=%0h vy=%0h",
                     $time, exp_v.vx, exp_v.vy, velocity_x, velocity_y);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        velocity_queue.push_back(predict_velocity(start_x, start_y, target_x, target_y,
                                                  magnitude));
      pending <= velocity_queue.size();
    end
  end
endmodule

/* tb/tb_velocity_toward_target.sv */
// Top of the velocity_toward_target testbench: clock, reset and request stimulus.
// Depends on vtt_pkg, velocity_toward_target and vtt_checker.
`timescale 1ns / 1ps
module tb_velocity_toward_target;
  import vtt_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CoordW-1:0] start_x, start_y, target_x, target_y, magnitude;
  logic              done;
  logic [OutW-1:0]   velocity_x, velocity_y;
  int                fail_count;
  int                pending;

  localparam logic [CoordW-1:0] MaxPos = 24'h7FFFFF;
  localparam logic [CoordW-1:0] MinNeg = 24'h800000;
  localparam logic [CoordW-1:0] MaxMag = 24'hFFFFFF;

  velocity_toward_target i_dut (.*);
  vtt_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive one request at the falling edge and hold it until accepted
  task automatic send_request(input logic [CoordW-1:0] sx, sy, tx, ty, mag);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    target_x <= tx;
    target_y <= ty;
    magnitude <= mag;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [CoordW-1:0] random_coord(input int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2000)) - 1000);
      2: return ($urandom_range(0, 1) != 0) ? MaxPos : MinNeg;
      default: return 24'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [CoordW-1:0] p, q;
    int mode;
    rst = 1'b1;
    start = 1'b0;
    {start_x, start_y, target_x, target_y, magnitude} = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, coincident points, axes and diagonals
    send_request('0, '0, '0, '0, '0);
    send_request('0, '0, '0, '0, MaxMag);
    send_request(MaxPos, MinNeg, MaxPos, MinNeg, 24'h000100);
    send_request(MinNeg, MinNeg, MaxPos, MaxPos, MaxMag);
    send_request(MaxPos, MaxPos, MinNeg, MinNeg, MaxMag);
    send_request(MinNeg, MaxPos, MaxPos, MinNeg, MaxMag);
    send_request(MaxPos, MinNeg, MinNeg, MaxPos, 24'h000001);
    send_request('0, '0, 24'h000001, '0, MaxMag);
    send_request('0, '0, '0, 24'hFFFFFF, MaxMag);
    send_request('0, '0, 24'h000001, 24'h000001, MaxMag);
    send_request('0, '0, 24'hFFFFFF, 24'h000001, 24'h000100);
    send_request('0, '0, 24'h000300, 24'h000400, 24'h000500);
    send_request(24'hFFFFFF, '0, '0, 24'hFFFFFF, 24'h800000);
    send_request(MinNeg, '0, MaxPos, '0, 24'h7FFFFF);
    send_request('0, MinNeg, '0, MaxPos, 24'h555555);
    send_request(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 24'hAAAAAA);

    // Random: mixed coordinate scales, some coincident points
    repeat (950) begin
      mode = $urandom_range(0, 3);
      p = random_coord(mode);
      q = random_coord(mode);
      if ($urandom_range(0, 19) == 0)
        send_request(p, q, p, q, 24'($urandom));
      else
        send_request(p, q, random_coord(mode), random_coord(mode),
                     ($urandom_range(0, 7) == 0) ? MaxMag : 24'($urandom));
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Guard against a hung run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
